// ----- sv/lmn_pkg.sv -----
package lmn_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_LOCAL_REQ = 2'd0,
        CMD_MESSAGE   = 2'd1,
        CMD_CHECK     = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_BCAST    = 3'd1;
    localparam logic [2:0] ACT_REPLY    = 3'd2;
    localparam logic [2:0] ACT_ENTER    = 3'd3;
    localparam logic [2:0] ACT_BAD_REL  = 3'd4;
    localparam logic [2:0] ACT_OVERFLOW = 3'd5;

    localparam logic [1:0] ADDR_SELF_ID    = 2'd0;
    localparam logic [1:0] ADDR_NODE_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_POP,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input beat, advance clock on request or message
        logic scan_start; // reset the head search
        logic scan_step;  // compare one entry
        logic decide;     // settle action and state
        logic pop;        // move last entry into head slot
        logic present;    // load output register
    } t_cmd_bus;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic need_pop;
    } t_stat_bus;

endpackage

// ----- sv/lmn_ctrl.sv -----
module lmn_ctrl
    import lmn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_beat,
    input  logic      i_out_free,
    input  t_stat_bus i_stat,
    output t_cmd_bus  o_cmd,
    output logic      o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_beat) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.need_pop ? ST_POP : ST_OUT;
            end
            ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.present = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
endmodule

// ----- sv/lmn_dp.sv -----
module lmn_dp
    import lmn_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd_bus    i_cmd,
    input  logic [1:0]  i_cmd_f,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_sender,
    input  logic [31:0] i_stamp,
    input  logic [3:0]  i_self_id,
    input  logic [4:0]  i_node_count,
    output t_stat_bus   o_stat,
    output logic [2:0]  o_action,
    output logic [3:0]  o_dest,
    output logic [31:0] o_clock
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [31:0] r_stamp_mem [MAX_NODES];
    logic [3:0]  r_id_mem    [MAX_NODES];

    logic [31:0]    r_clock;
    logic [CW-1:0]  r_count;
    logic [MAX_NODES-1:0] r_seen;
    logic [1:0]     r_cmd;
    logic [1:0]     r_kind;
    logic [3:0]     r_sender;
    logic [31:0]    r_stamp;
    logic           r_pushed;
    logic [CW-1:0]  r_idx;
    logic [IW-1:0]  r_best;
    logic [31:0]    r_bstamp;
    logic [3:0]     r_bid;
    logic [2:0]     r_act;
    logic [3:0]     r_dst;
    logic [31:0]    r_es;
    logic [3:0]     r_eid;
    logic [CW-1:0]  r_ecur;
    logic           r_rd_vld;

    logic [31:0] w_max;
    logic [31:0] w_inc;
    logic        w_full;
    logic [31:0] w_ps;
    logic [3:0]  w_pid;
    logic [CW-1:0] w_cnt_after;
    logic        w_better;
    logic [5:0]  w_ones;
    logic [5:0]  w_need;
    logic        w_has;
    logic        w_pop;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CLOCK_MAX) ? CLOCK_MAX : v + 32'd1;
    endfunction

    assign w_max  = (r_clock > i_stamp) ? r_clock : i_stamp;
    assign w_full = (r_count >= CW'(MAX_NODES));
    assign w_inc  = sat_inc(r_clock);

    // entry read during scan is registered and arrives in the cycle after its address
    assign w_better = (r_es < r_bstamp) || ((r_es == r_bstamp) && (r_eid < r_bid));
    assign o_stat.scan_done = (r_idx >= r_count) && !r_rd_vld;
    assign o_stat.need_pop  = w_pop;

    always_comb begin
        w_ones = '0;
        for (int k = 0; k < MAX_NODES; k++) begin
            w_ones = w_ones + 6'(r_seen[k]);
        end
    end
    assign w_need = (i_node_count == 5'd0) ? 6'd0 : 6'(i_node_count - 5'd1);
    assign w_has  = (r_count != '0);
    assign w_pop  = ((r_cmd == CMD_MESSAGE) && (r_kind == KIND_RELEASE) && w_has &&
                     (r_bid == r_sender)) ||
                    ((r_cmd == CMD_CHECK) && w_has && (r_bid == i_self_id) &&
                     (w_ones == w_need));

    always_comb begin
        w_ps  = i_stamp;
        w_pid = i_sender;
        if (i_cmd_f == CMD_LOCAL_REQ) begin
            w_ps  = w_inc;
            w_pid = i_self_id;
        end
    end
    assign w_cnt_after = r_count + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
            r_count <= '0;
            r_seen  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cmd    <= i_cmd_f;
                r_kind   <= i_kind;
                r_sender <= i_sender;
                r_stamp  <= i_stamp;
                r_pushed <= 1'b0;
                if (i_cmd_f == CMD_LOCAL_REQ) begin
                    r_clock <= w_inc;
                end else if (i_cmd_f == CMD_MESSAGE) begin
                    r_clock <= sat_inc(w_max);
                end
                // push now so the scan sees the new entry
                if (!w_full && ((i_cmd_f == CMD_LOCAL_REQ) ||
                    (i_cmd_f == CMD_MESSAGE && i_kind == KIND_REQUEST))) begin
                    r_stamp_mem[r_count[IW-1:0]] <= w_ps;
                    r_id_mem[r_count[IW-1:0]]    <= w_pid;
                    r_count  <= w_cnt_after;
                    r_pushed <= 1'b1;
                end
            end
            if (i_cmd.scan_start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_best   <= '0;
                r_bstamp <= CLOCK_MAX;
                r_bid    <= 4'hF;
            end else if (i_cmd.scan_step) begin
                // issue the read of one entry and compare the one read before
                r_es     <= r_stamp_mem[r_idx[IW-1:0]];
                r_eid    <= r_id_mem[r_idx[IW-1:0]];
                r_ecur   <= r_idx;
                r_rd_vld <= (r_idx < r_count);
                if (r_idx < r_count) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rd_vld && (r_ecur == '0 || w_better)) begin
                    r_best   <= r_ecur[IW-1:0];
                    r_bstamp <= r_es;
                    r_bid    <= r_eid;
                end
            end
            if (i_cmd.decide) begin
                r_act <= ACT_NONE;
                r_dst <= '0;
                unique case (r_cmd)
                    CMD_LOCAL_REQ: r_act <= r_pushed ? ACT_BCAST : ACT_OVERFLOW;
                    CMD_MESSAGE: begin
                        if (r_kind == KIND_REQUEST) begin
                            if (!r_pushed) begin
                                r_act <= ACT_OVERFLOW;
                            end else if (r_bid != i_self_id) begin
                                r_act <= ACT_REPLY;
                                r_dst <= r_sender;
                            end
                        end else if (r_kind == KIND_REPLY) begin
                            r_seen[r_sender] <= 1'b1;
                        end else if (r_kind == KIND_RELEASE) begin
                            if (!w_has || r_bid != r_sender) begin
                                r_act <= ACT_BAD_REL;
                            end
                        end
                    end
                    CMD_CHECK: begin
                        if (w_pop) begin
                            r_clock <= w_inc;
                            r_seen  <= '0;
                            r_act   <= ACT_ENTER;
                        end
                    end
                    default: r_act <= ACT_NONE;
                endcase
            end
            if (i_cmd.pop) begin
                r_stamp_mem[r_best] <= r_stamp_mem[r_count[IW-1:0] - IW'(1)];
                r_id_mem[r_best]    <= r_id_mem[r_count[IW-1:0] - IW'(1)];
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_action = r_act;
    assign o_dest   = r_dst;
    assign o_clock  = r_clock;
endmodule

// ----- sv/lamport_mutex_node.sv -----
// One node of Lamport distributed mutual exclusion. Each input beat (local
// request, received message or check) yields exactly one result beat
// carrying the action, the reply destination and the logical clock after
// the step. The head of the request queue is found by a scan that reads
// one stored entry per cycle and compares it in the next cycle, and a
// pop adds the ST_POP state before the output. The result is held in an
// output register; the next beat is taken once it has been presented, and
// a result still waiting at the output holds the next one back.
// Configuration writes go through the APB port; the user must write them
// only while the node is idle, as the block does not enforce it;
// reads return self_id and node_count.
module lamport_mutex_node
    import lmn_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [3:2] msg_kind, [7:4] sender, [39:8] stamp
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] action, [6:3] dest, [38:7] clock_out, [39] zero
    output logic [39:0] m_axis_tdata
);
    logic [3:0]  r_self_id;
    logic [4:0]  r_node_count;
    logic        r_ovalid;
    logic [38:0] r_odata;
    logic        w_in_beat;
    logic        w_busy;
    logic [2:0]  w_act;
    logic [3:0]  w_dst;
    logic [31:0] w_clk;
    t_cmd_bus    w_cmd;
    t_stat_bus   w_stat;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id    <= '0;
            r_node_count <= 5'd2;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_NODE_COUNT[0]) begin
                r_node_count <= pwdata[4:0];
            end else if (paddr[2] == ADDR_SELF_ID[0]) begin
                r_self_id <= pwdata[3:0];
            end
        end
    end
    assign prdata = paddr[2] ? {27'd0, r_node_count} : {28'd0, r_self_id};

    assign s_axis_tready = !w_busy;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;

    lmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (w_in_beat),
        .i_out_free (!r_ovalid || m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    lmn_dp #(.MAX_NODES(MAX_NODES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_f      (s_axis_tdata[1:0]),
        .i_kind       (s_axis_tdata[3:2]),
        .i_sender     (s_axis_tdata[7:4]),
        .i_stamp      (s_axis_tdata[39:8]),
        .i_self_id    (r_self_id),
        .i_node_count (r_node_count),
        .o_stat       (w_stat),
        .o_action     (w_act),
        .o_dest       (w_dst),
        .o_clock      (w_clk)
    );

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.present) begin
            r_ovalid <= 1'b1;
            r_odata  <= {w_clk, w_dst, w_act};
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_odata};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !s_axis_tready)
        else $error("beat accepted while busy");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");
    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= ACT_OVERFLOW))
        else $error("bad action code");
endmodule
